/* src/pcs_pkg.sv */
// ----------------------------------------------------------------------------
// pcs_pkg
// shared types, constants and the led code table of the column scanner
// ----------------------------------------------------------------------------
package pcs_pkg;

    localparam int COLUMNS = 7;
    localparam logic [3:0] COLUMNS_W = 4'(COLUMNS);

    // image geometry: seven columns of seven led bits
    localparam int IMAGE_W = 49;
    localparam logic [5:0] LEDS_PER_COL = 6'd7;
    localparam logic [3:0] IMAGE_COLS = 4'd7;
    localparam logic [2:0] DARK_LED = 3'd7;
    localparam logic [2:0] PARK_COLUMN = 3'd5;
    localparam logic [4:0] PULLUP_BIT = 5'h10;

    // register map, byte address 8*index
    localparam int PADDR_W = 5;
    localparam logic [1:0] REG_IMAGE = 2'd0;
    localparam logic [1:0] REG_PRESCALE = 2'd1;
    localparam logic [1:0] REG_REFRACTORY = 2'd2;

    localparam logic [7:0] PRESCALE_RESET = 8'd80;
    localparam logic [15:0] REFRACTORY_RESET = 16'd800;
    localparam logic [15:0] PERIOD_RESET = 16'd500;

    typedef struct packed {
        logic [7:0]  fast_count;
        logic [15:0] slow_timer;
        logic [2:0]  column_index;
        logic        reversed;
        logic [2:0]  led_index;
        logic [15:0] swing_period;
        logic [15:0] refractory_count;
        logic        refractory_running;
        logic        switch_latched;
    } pcs_state_t;

    typedef struct packed {
        logic [IMAGE_W-1:0] image_bits;
        logic [7:0]         prescale_limit;
        logic [15:0]        refractory_limit;
    } pcs_cfg_t;

    typedef struct packed {
        logic [4:0] port_drive;
        logic [3:0] direction_drive;
        logic       swing_event;
    } pcs_result_t;

    function automatic logic [7:0] led_code(input logic [2:0] idx);
        logic [7:0] code;
        case (idx)
            3'd0: code = 8'h51;
            3'd1: code = 8'h54;
            3'd2: code = 8'hC8;
            3'd3: code = 8'hC4;
            3'd4: code = 8'h91;
            3'd5: code = 8'h98;
            3'd6: code = 8'h31;
            3'd7: code = 8'h32;
            default: code = 8'h00;
        endcase
        return code;
    endfunction

endpackage

/* src/pcs_step.sv */
// ----------------------------------------------------------------------------
// pcs_step
// one tick of the scanner: switch rule, timers, column order and led drive
// ----------------------------------------------------------------------------
module pcs_step import pcs_pkg::*; (
    input  pcs_state_t  cur,
    input  pcs_cfg_t    cfg,
    input  logic        switch_open,
    output pcs_state_t  nxt,
    output pcs_result_t res
);

    logic [16:0] period_sum;
    logic [3:0]  col_inc;
    logic [3:0]  col_sel;
    logic [5:0]  bit_idx;
    logic [7:0]  code;

    assign period_sum = {1'b0, cur.swing_period} + {1'b0, cur.slow_timer};

    always_comb begin
        nxt = cur;
        res = '0;
        col_inc = '0;
        col_sel = '0;
        bit_idx = '0;
        code = led_code(cur.led_index);

        // switch rule
        if (switch_open) begin
            nxt.refractory_running = 1'b1;
            if (cur.refractory_count > cfg.refractory_limit) begin
                nxt.switch_latched = 1'b0;
                nxt.refractory_running = 1'b0;
            end
        end else begin
            if (!cur.switch_latched) begin
                nxt.swing_period = period_sum[16:1];
                nxt.slow_timer = '0;
                nxt.fast_count = '0;
                nxt.reversed = 1'b0;
                res.swing_event = 1'b1;
            end
            nxt.refractory_running = 1'b0;
            nxt.refractory_count = '0;
            nxt.switch_latched = 1'b1;
        end

        // prescaled timer and column advance
        nxt.fast_count = nxt.fast_count + 8'd1;
        if (nxt.fast_count > cfg.prescale_limit) begin
            nxt.slow_timer = nxt.slow_timer + 16'd1;
            nxt.fast_count = '0;
            col_inc = {1'b0, nxt.column_index} + 4'd1;
            if (col_inc >= COLUMNS_W) begin
                nxt.column_index = 3'd0;
            end else begin
                nxt.column_index = col_inc[2:0];
            end
        end

        // reverse at half period
        if (!nxt.reversed && nxt.slow_timer > {1'b0, nxt.swing_period[15:1]}) begin
            nxt.reversed = 1'b1;
            nxt.column_index = 3'd0;
        end

        // blank until the phase delay, else drive the current led
        if (nxt.slow_timer > {3'b0, nxt.swing_period[15:3]}) begin
            if ({1'b0, nxt.column_index} < COLUMNS_W) begin
                col_sel = nxt.reversed ? (COLUMNS_W - 4'd1 - {1'b0, nxt.column_index})
                                       : {1'b0, nxt.column_index};
                if (col_sel < IMAGE_COLS && cur.led_index != DARK_LED) begin
                    bit_idx = 6'({3'b0, col_sel[2:0]} * LEDS_PER_COL) + {3'b0, cur.led_index};
                    if (cfg.image_bits[bit_idx]) begin
                        res.port_drive = {1'b0, code[3:0]} | PULLUP_BIT;
                        res.direction_drive = code[7:4];
                    end
                end
            end
        end else begin
            nxt.column_index = PARK_COLUMN;
        end

        nxt.led_index = cur.led_index + 3'd1;
        if (nxt.refractory_running) begin
            nxt.refractory_count = nxt.refractory_count + 16'd1;
        end
    end

endmodule

/* src/pcs_regs.sv */
// ----------------------------------------------------------------------------
// pcs_regs
// apb register file: image, prescale limit and refractory limit
// ----------------------------------------------------------------------------
module pcs_regs import pcs_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready,
    output pcs_cfg_t           cfg
);

    pcs_cfg_t   cfg_reg;
    logic [1:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[PADDR_W-1:3];
    assign wr_en = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.image_bits <= '0;
            cfg_reg.prescale_limit <= PRESCALE_RESET;
            cfg_reg.refractory_limit <= REFRACTORY_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                REG_IMAGE:      cfg_reg.image_bits <= pwdata[IMAGE_W-1:0];
                REG_PRESCALE:   cfg_reg.prescale_limit <= pwdata[7:0];
                REG_REFRACTORY: cfg_reg.refractory_limit <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_IMAGE:      prdata = {{(64-IMAGE_W){1'b0}}, cfg_reg.image_bits};
            REG_PRESCALE:   prdata = {56'b0, cfg_reg.prescale_limit};
            REG_REFRACTORY: prdata = {48'b0, cfg_reg.refractory_limit};
            default:        prdata = '0;
        endcase
    end

endmodule

/* src/pov_column_scanner_sync.sv */
// ----------------------------------------------------------------------------
// pov_column_scanner_sync
// persistence-of-vision column scanner driven by tilt-switch ticks
// ----------------------------------------------------------------------------
// each request on the s_ channel is one timer tick carrying the tilt switch
// level (s_switch_open). every tick yields exactly one result on the m_
// channel: the charlieplex port and direction codes for the current led and
// a flag for a newly accepted switch closure.
// the tick is held in an input register, the scan step runs as one pass of
// combinational logic, and the result lands in the output register, so a
// result shows on m_valid once its tick has passed from the input register
// into the output register. one request per cycle is sustained while m_ready
// holds; the state register takes the update of one tick and feeds the next.
// when the receiver stalls, the result is held in the output register and
// one more request is taken into the input register; s_ready then drops
// until m_ready returns.
// reset (aresetn low, synchronous) empties both registers, clears timers and
// latch, sets the period estimate to 500 and the registers to defaults. the
// user keeps apb port (8-byte register stride) writes to idle; not enforced.
// ----------------------------------------------------------------------------
module pov_column_scanner_sync import pcs_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_switch_open,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [4:0]         m_port_drive,
    output logic [3:0]         m_direction_drive,
    output logic               m_swing_event,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready
);

    pcs_cfg_t    cfg;
    pcs_state_t  state_reg;
    pcs_state_t  state_next;
    pcs_result_t res_next;
    pcs_result_t res_reg;
    logic        in_valid_reg;
    logic        in_switch_reg;
    logic        out_valid_reg;
    logic        advance;

    pcs_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pcs_step u_step (
        .cur         (state_reg),
        .cfg         (cfg),
        .switch_open (in_switch_reg),
        .nxt         (state_next),
        .res         (res_next)
    );

    // the held tick moves on when the output slot is free or being taken
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg <= '{swing_period: PERIOD_RESET, default: '0};
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                state_reg <= state_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_switch_reg <= s_switch_open;
        end
        if (advance) begin
            res_reg <= res_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_port_drive = res_reg.port_drive;
    assign m_direction_drive = res_reg.direction_drive;
    assign m_swing_event = res_reg.swing_event;

endmodule

/* src/pcs_checker.sv */
// ----------------------------------------------------------------------------
// pcs_checker
// port-level checks of the column scanner, bound to the top level
// ----------------------------------------------------------------------------
module pcs_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [4:0] m_port_drive,
    input logic [3:0] m_direction_drive,
    input logic       m_swing_event
);

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_port_drive)
            && $stable(m_direction_drive) && $stable(m_swing_event))
        else $error("stalled result changed");

    // a lit led always drives both port and direction nibbles
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_port_drive == 5'd0) == (m_direction_drive == 4'd0)))
        else $error("port and direction codes disagree on lit led");

    // a lit port carries the pullup bit
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_port_drive != 5'd0 |-> m_port_drive[4])
        else $error("lit port without pullup");

    // an empty output slot never blocks the input
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input blocked with empty output");

    // reset empties the output
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind pov_column_scanner_sync pcs_checker u_pcs_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .s_ready           (s_ready),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_port_drive      (m_port_drive),
    .m_direction_drive (m_direction_drive),
    .m_swing_event     (m_swing_event)
);
